FILE: hw/rtl/pprd_pkg.sv
// Shared types and constants for the PPG pulse rate detector.
// Used by pprd_ctrl, pprd_dp and ppg_pulse_rate_detector_top; no dependencies.
package pprd_pkg;

    // Fixed field widths
    localparam int FRAC_BITS  = 16;   // fraction bits of the average and of alpha
    localparam int TIME_W     = 32;   // timestamps and window levels
    localparam int CFG_W      = 16;   // every config register
    localparam int CFG_IDX_W  = 8;    // register index on the config port
    localparam int RATE_W     = 16;   // pulse rate

    // Rate divider: 60000 / interval, one quotient bit per cycle
    localparam logic [RATE_W-1:0] BPM_NUM = 16'd60000;
    localparam int DIV_STEPS  = RATE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Config register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_ALPHA     = 8'd0,
        CFG_STALE_MS      = 8'd1,
        CFG_REFRACTORY_MS = 8'd2,
        CFG_WARMUP_MS     = 8'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_EMA_ALPHA     = 16'd3932;
    localparam logic [CFG_W-1:0] RST_STALE_MS      = 16'd4000;
    localparam logic [CFG_W-1:0] RST_REFRACTORY_MS = 16'd500;
    localparam logic [CFG_W-1:0] RST_WARMUP_MS     = 16'd10;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_EXTREME,
        ST_WINDOW,
        ST_PEAK,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic extreme;
        logic window;
        logic peak;
        logic div_step;
        logic div_last;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic peak_hit;
    } t_dp_stat;

endpackage

FILE: hw/rtl/pprd_ctrl.sv
// Sequencing controller for the pulse rate detector.
// Depends on pprd_pkg; drives pprd_dp through t_dp_cmd.
module pprd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  pprd_pkg::t_dp_stat i_stat,
    output pprd_pkg::t_dp_cmd  o_cmd
);
    import pprd_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid;
    logic                 out_free;
    logic                 div_done;

    assign out_free = !r_out_valid || !i_out_stall;
    assign div_done = (r_div_cnt == DIV_LAST);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_A;
            ST_MUL_A:   n_state = ST_MUL_B;
            ST_MUL_B:   n_state = ST_SUM;
            ST_SUM:     n_state = ST_EXTREME;
            ST_EXTREME: n_state = ST_WINDOW;
            ST_WINDOW:  n_state = ST_PEAK;
            ST_PEAK:    n_state = i_stat.peak_hit ? ST_DIVIDE : ST_OUTPUT;
            ST_DIVIDE:  if (div_done) n_state = ST_OUTPUT;
            ST_OUTPUT:  if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Divider step counter
    always_comb begin
        n_div_cnt = r_div_cnt;
        if (r_state == ST_PEAK) begin
            n_div_cnt = '0;
        end else if (r_state == ST_DIVIDE) begin
            n_div_cnt = r_div_cnt + 1'b1;
        end
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:    o_cmd.capture  = i_in_valid;
            ST_MUL_A:   o_cmd.mul_a    = 1'b1;
            ST_MUL_B:   o_cmd.mul_b    = 1'b1;
            ST_SUM:     o_cmd.sum      = 1'b1;
            ST_EXTREME: o_cmd.extreme  = 1'b1;
            ST_WINDOW:  o_cmd.window   = 1'b1;
            ST_PEAK:    o_cmd.peak     = 1'b1;
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = div_done;
            end
            ST_OUTPUT:  o_cmd.load_out = out_free;
            default:    o_cmd = '0;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_MUL_A))
        else $error("accepted beat did not start the multiply");

    a_out_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUTPUT))
        else $error("result raised outside the output state");

    a_peak_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PEAK && i_stat.peak_hit) |=>
        (r_state == ST_DIVIDE && r_div_cnt == '0))
        else $error("peak did not start a fresh division");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && div_done) |=> (r_state == ST_OUTPUT))
        else $error("division did not finish after the last step");
`endif

endmodule

FILE: hw/rtl/pprd_dp.sv
// Datapath of the pulse rate detector: shared multiplier, average, window,
// peak test and restoring rate divider. Depends on pprd_pkg.
module pprd_dp #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pprd_pkg::t_dp_cmd              i_cmd,
    output pprd_pkg::t_dp_stat             o_stat,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [pprd_pkg::TIME_W-1:0]    i_time_ms,
    input  logic [pprd_pkg::CFG_W-1:0]     i_ema_alpha,
    input  logic [pprd_pkg::CFG_W-1:0]     i_stale_ms,
    input  logic [pprd_pkg::CFG_W-1:0]     i_refractory_ms,
    input  logic [pprd_pkg::CFG_W-1:0]     i_warmup_ms,
    output logic [SAMPLE_BITS-1:0]         o_filtered,
    output logic [pprd_pkg::RATE_W-1:0]    o_pulse_bpm,
    output logic                           o_peak_found
);
    import pprd_pkg::*;

    localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int PROD_W = WGT_W + AVG_W;
    localparam int EXT_W  = TIME_W + FRAC_BITS;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

    // Captured beat
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_W-1:0]      r_time;

    // Average
    logic [AVG_W-1:0]       r_term;
    logic [PROD_W-1:0]      r_prod;
    logic [AVG_W-1:0]       r_avg;

    // Window and peak history
    logic [TIME_W-1:0]      r_max_lvl, r_max_time, r_min_lvl, r_min_time;
    logic [SAMPLE_BITS-1:0] r_prior_lvl, r_older_lvl;
    logic [TIME_W-1:0]      r_prior_time, r_peak_time;
    logic [RATE_W-1:0]      r_rate;
    logic                   r_peak;

    // Divider
    logic [TIME_W-1:0]      r_den;
    logic [RATE_W-1:0]      r_quo, n_quo;
    logic [RATE_W-1:0]      r_rem, n_rem;

    // Result register
    logic [SAMPLE_BITS-1:0] r_out_filt;
    logic [RATE_W-1:0]      r_out_bpm;
    logic                   r_out_peak;

    logic [WGT_W-1:0]       mul_x;
    logic [AVG_W-1:0]       mul_y;
    logic [PROD_W-1:0]      mul_p;
    logic [PROD_W-1:0]      acc;
    logic [AVG_W-1:0]       n_avg;
    logic [SAMPLE_BITS-1:0] lvl;
    logic [TIME_W-1:0]      lvl_w;
    logic                   max_hit, min_hit;
    logic [TIME_W-1:0]      span;
    logic                   nudge;
    logic [TIME_W-1:0]      thr, interval;
    logic                   peak_hit;
    logic [RATE_W:0]        rem_sh;
    logic                   quo_bit;

    // Shared multiplier: alpha * sample, then (1 - alpha) * average
    always_comb begin
        if (i_cmd.mul_a) begin
            mul_x = WGT_W'(i_ema_alpha);
            mul_y = AVG_W'(r_sample);
        end else begin
            mul_x = WGT_ONE - WGT_W'(i_ema_alpha);
            mul_y = r_avg;
        end
    end
    assign mul_p = mul_x * mul_y;

    // Weighted sum, scaled back to Q.16
    assign acc   = PROD_W'({r_term, FRAC_BITS'(0)}) + r_prod;
    assign n_avg = acc[AVG_W+FRAC_BITS-1:FRAC_BITS];

    assign lvl   = r_avg[AVG_W-1:FRAC_BITS];
    assign lvl_w = TIME_W'(lvl);

    // Extreme replacement tests
    assign max_hit = (EXT_W'(r_avg) > {r_max_lvl, FRAC_BITS'(0)}) ||
                     (r_time > r_max_time + TIME_W'(i_stale_ms));
    assign min_hit = (EXT_W'(r_avg) < {r_min_lvl, FRAC_BITS'(0)}) ||
                     (r_time > r_min_time + TIME_W'(i_stale_ms));

    // Window rule: after warmup, any nonzero span pulls the older extreme in by one
    assign span  = r_max_lvl - r_min_lvl;
    assign nudge = (span != '0) && (r_time > TIME_W'(i_warmup_ms));

    // Peak test on the previous level
    assign thr      = r_max_lvl - r_min_lvl - 1'b1;
    assign interval = r_prior_time - r_peak_time;
    assign peak_hit = (TIME_W'(r_prior_lvl) > thr) &&
                      ({r_prior_lvl, FRAC_BITS'(0)} >= r_avg) &&
                      (r_prior_lvl >= r_older_lvl) &&
                      (interval > TIME_W'(i_refractory_ms));
    assign o_stat.peak_hit = peak_hit;

    // One restoring division step
    always_comb begin
        rem_sh  = {r_rem, r_quo[RATE_W-1]};
        quo_bit = (TIME_W'(rem_sh) >= r_den);
        n_rem   = quo_bit ? RATE_W'(rem_sh - r_den[RATE_W:0]) : RATE_W'(rem_sh);
        n_quo   = {r_quo[RATE_W-2:0], quo_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg        <= '0;
            r_max_lvl    <= '0;
            r_max_time   <= '0;
            r_min_lvl    <= '0;
            r_min_time   <= '0;
            r_prior_lvl  <= '0;
            r_prior_time <= '0;
            r_older_lvl  <= '0;
            r_peak_time  <= '0;
            r_rate       <= '0;
        end else begin
            if (i_cmd.sum) begin
                r_avg <= n_avg;
            end
            if (i_cmd.extreme) begin
                if (max_hit) begin
                    r_max_lvl  <= lvl_w;
                    r_max_time <= r_time;
                end else if (min_hit) begin
                    r_min_lvl  <= lvl_w;
                    r_min_time <= r_time;
                end
            end
            if (i_cmd.window && nudge) begin
                if (r_max_time > r_min_time) begin
                    r_min_lvl  <= r_min_lvl + 1'b1;
                    r_min_time <= r_max_time - 1'b1;
                end else begin
                    r_max_lvl  <= r_max_lvl - 1'b1;
                    r_max_time <= r_min_time - 1'b1;
                end
            end
            if (i_cmd.peak) begin
                if (peak_hit) begin
                    r_peak_time <= r_prior_time;
                end
                r_older_lvl  <= r_prior_lvl;
                r_prior_lvl  <= lvl;
                r_prior_time <= r_time;
            end
            if (i_cmd.div_last) begin
                r_rate <= n_quo;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
            r_time   <= i_time_ms;
        end
        if (i_cmd.mul_a) begin
            r_term <= AVG_W'(mul_p);
        end
        if (i_cmd.mul_b) begin
            r_prod <= mul_p;
        end
        if (i_cmd.peak) begin
            r_peak <= peak_hit;
            r_den  <= interval;
            r_quo  <= BPM_NUM;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.load_out) begin
            r_out_filt <= lvl;
            r_out_bpm  <= r_rate;
            r_out_peak <= r_peak;
        end
    end

    assign o_filtered   = r_out_filt;
    assign o_pulse_bpm  = r_out_bpm;
    assign o_peak_found = r_out_peak;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den != '0))
        else $error("rate division by a zero interval");

    a_peak_loads_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.peak && peak_hit) |=> (r_peak_time == $past(r_prior_time)))
        else $error("peak time not taken from the previous sample");

    a_avg_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |=> (r_avg <= $past(r_avg) ||
                       r_avg[AVG_W-1:FRAC_BITS] <= $past(r_sample)))
        else $error("average rose above the new sample");
`endif

endmodule

FILE: hw/rtl/ppg_pulse_rate_detector_top.sv
// PPG pulse rate detector, top level: configuration registers and the
// controller/datapath pair. Depends on pprd_pkg, pprd_ctrl and pprd_dp.
//
// Usage:
//   Input channel  (i_in_valid / o_in_stall): one beat = i_sample + i_time_ms.
//   Output channel (o_out_valid / i_out_stall): one beat per input beat,
//     carrying o_filtered, o_pulse_bpm and o_peak_found.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 alpha,
//     1 stale time, 2 refractory time, 3 warmup time; other indexes ignored.
//     Write only while no beat is in flight.
// Sequencing: one beat at a time. The result is registered after the
//   multiply, sum, extreme, window and peak states, and after the serial
//   divide for the rate when a peak is found. The next beat is taken once
//   the block is back in idle after the result is loaded.
// The stages run in order through one shared 17-bit by (SAMPLE_BITS+16)-bit
//   multiplier (two passes) and the one-bit-per-cycle divider.
// Stall: a held result keeps the block in its output state; it takes no new
//   beat until the result register frees up.
// Reset (i_rst_n low, synchronous): config registers take their defaults,
//   average, window, history and rate clear to zero, no result pending.
module ppg_pulse_rate_detector_top #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic [pprd_pkg::TIME_W-1:0]      i_time_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [SAMPLE_BITS-1:0]           o_filtered,
    output logic [pprd_pkg::RATE_W-1:0]      o_pulse_bpm,
    output logic                             o_peak_found,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pprd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pprd_pkg::CFG_W-1:0]       i_cfg_data
);
    import pprd_pkg::*;

    logic [CFG_W-1:0] r_ema_alpha, r_stale_ms, r_refractory_ms, r_warmup_ms;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_alpha     <= RST_EMA_ALPHA;
            r_stale_ms      <= RST_STALE_MS;
            r_refractory_ms <= RST_REFRACTORY_MS;
            r_warmup_ms     <= RST_WARMUP_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EMA_ALPHA:     r_ema_alpha     <= i_cfg_data;
                CFG_STALE_MS:      r_stale_ms      <= i_cfg_data;
                CFG_REFRACTORY_MS: r_refractory_ms <= i_cfg_data;
                CFG_WARMUP_MS:     r_warmup_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pprd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pprd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_sample        (i_sample),
        .i_time_ms       (i_time_ms),
        .i_ema_alpha     (r_ema_alpha),
        .i_stale_ms      (r_stale_ms),
        .i_refractory_ms (r_refractory_ms),
        .i_warmup_ms     (r_warmup_ms),
        .o_filtered      (o_filtered),
        .o_pulse_bpm     (o_pulse_bpm),
        .o_peak_found    (o_peak_found)
    );

endmodule
